[src/tgsg_pkg.sv]
`timescale 1ns / 1ps
package tgsg_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;

	localparam logic [CFG_IDX_W-1:0] REG_SWING    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RATE     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PMIN     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PMAX     = 3'd5;

	localparam logic [6:0]  RST_SWING    = 7'd30;
	localparam logic [7:0]  RST_CENTER   = 8'd90;
	localparam logic [14:0] RST_DEADBAND = 15'd1638;
	localparam logic [11:0] RST_RATE     = 12'd109;
	localparam logic [14:0] RST_PMIN     = 15'd544;
	localparam logic [14:0] RST_PMAX     = 15'd2400;

	// degrees to centidegrees
	localparam logic [13:0] CENTI = 14'd100;
	localparam logic [14:0] ANGLE_MAX = 15'd18000;
	// floor(2^30 / 18000)
	localparam logic [15:0] RECIP_ANGLE = 16'd59652;
	// us * 4096 / 20000 == (us * 128) / 625
	localparam logic [9:0]  TICK_DIV   = 10'd625;
	localparam logic [12:0] RECIP_TICK = 13'd6710;
	localparam logic [11:0] TICK_MAX   = 12'd4095;

	localparam logic [63:0] K_C1 = 64'd1686629713;
	localparam logic [63:0] K_C3 = 64'd693598668;
	localparam logic [63:0] K_C5 = 64'd85569306;
	localparam logic [63:0] K_C7 = 64'd5026995;
	localparam logic [63:0] K_C9 = 64'd172272;
	localparam logic [63:0] Q30_HALF = 64'd536870912;

	typedef struct packed {
		logic [6:0]  swing;
		logic [7:0]  center;
		logic [14:0] deadband;
		logic [11:0] rate;
		logic [14:0] pmin;
		logic [14:0] pmax;
	} tgsg_cfg_t;

	typedef struct packed {
		logic        walk;
		logic [15:0] phase;
		logic [15:0] fwd;
		logic [15:0] turn;
	} tgsg_tick_t;

	// quarter-wave sine entry, x is the Q30 position within the quarter
	function automatic logic [14:0] tgsg_sine_entry(input logic [63:0] x);
		logic [63:0] u;
		logic [63:0] p;
		logic [63:0] v;
		u = (x * x) >> 30;
		p = K_C9;
		p = K_C7 - ((p * u) >> 30);
		p = K_C5 - ((p * u) >> 30);
		p = K_C3 - ((p * u) >> 30);
		p = K_C1 - ((p * u) >> 30);
		p = (p * x) >> 30;
		v = (p * 64'd32767 + Q30_HALF) >> 30;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return v[14:0];
	endfunction

endpackage

[src/tripod_gait_servo_generator_unit.sv]
`timescale 1ns / 1ps
// Tripod gait servo generator.
// Input channel (in_valid/in_ready) takes one tick word: elapsed_ms and the
// Q1.15 forward_cmd and turn_cmd. Each tick yields LEG_COUNT output words
// (out_valid/out_ready) in leg order: leg, pulse_tick, and last on the final leg.
// Configuration channel (cfg_valid/cfg_ready) writes register cfg_index with
// cfg_data; cfg_ready is always high and unknown indexes are dropped. Write
// only while the block is idle.
// Timing: the front walks its idle, multiply and push states for each tick (phase
// multiply, then update and enqueue; push waits for queue room). The back pipeline
// issues one leg per cycle, while out_ready and the queue allow, from a 2-word queue
// and runs 10 register stages, s1 to s9 and the result register. The front can take
// and prepare the next tick while the back still issues the legs of the last one.
// Reset clears the gait phase to zero and loads the default registers; no
// clearing pass. When out_ready is low the whole back pipeline holds, the queue
// fills, and then in_ready drops until room returns.
module tripod_gait_servo_generator_unit import tgsg_pkg::*; #(
	parameter int LEG_COUNT        = 6,
	parameter int SINE_TABLE_DEPTH = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [9:0]            elapsed_ms,
	input  logic [15:0]           forward_cmd,
	input  logic [15:0]           turn_cmd,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            leg,
	output logic [11:0]           pulse_tick,
	output logic                  last,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	tgsg_cfg_t  cfg_q;
	logic       push;
	tgsg_tick_t push_data;
	logic       push_ready;
	logic       pop;
	logic       head_valid;
	tgsg_tick_t head_data;
	logic       mid_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.swing    <= RST_SWING;
			cfg_q.center   <= RST_CENTER;
			cfg_q.deadband <= RST_DEADBAND;
			cfg_q.rate     <= RST_RATE;
			cfg_q.pmin     <= RST_PMIN;
			cfg_q.pmax     <= RST_PMAX;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SWING:    cfg_q.swing    <= cfg_data[6:0];
				REG_CENTER:   cfg_q.center   <= cfg_data[7:0];
				REG_DEADBAND: cfg_q.deadband <= cfg_data[14:0];
				REG_RATE:     cfg_q.rate     <= cfg_data[11:0];
				REG_PMIN:     cfg_q.pmin     <= cfg_data[14:0];
				REG_PMAX:     cfg_q.pmax     <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	tgsg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.elapsed_ms (elapsed_ms),
		.forward_cmd(forward_cmd),
		.turn_cmd   (turn_cmd),
		.push       (push),
		.push_data  (push_data),
		.push_ready (push_ready)
	);

	tgsg_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	tgsg_back #(
		.LEG_COUNT        (LEG_COUNT),
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop),
		.mid_item   (mid_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.leg        (leg),
		.pulse_tick (pulse_tick),
		.last       (last)
	);

	a_front_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("front took a second tick while busy");

	a_last_leg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (leg == 3'(LEG_COUNT - 1))))
		else $error("last flag does not match final leg");

	a_mid_item: assert property (@(posedge clk) disable iff (!arst_n)
		mid_item |-> head_valid)
		else $error("tick left queue before all legs issued");

endmodule

[src/tgsg_front.sv]
`timescale 1ns / 1ps
module tgsg_front import tgsg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  tgsg_cfg_t   cfg,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [9:0]  elapsed_ms,
	input  logic [15:0] forward_cmd,
	input  logic [15:0] turn_cmd,
	output logic        push,
	output tgsg_tick_t  push_data,
	input  logic        push_ready
);

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_MUL  = 2'd1;
	localparam logic [1:0] F_PUSH = 2'd2;

	logic [1:0]  state_q;
	logic [15:0] phase_q;
	logic [9:0]  elapsed_q;
	logic [15:0] fwd_q;
	logic [15:0] turn_q;
	logic [25:0] prod_q;
	logic        walk_q;

	logic [15:0] mf;
	logic [15:0] mt;
	logic [15:0] speed;
	logic        walking;
	logic [37:0] inc_prod;
	logic [15:0] next_phase;

	assign mf      = fwd_q[15] ? (~fwd_q + 16'd1) : fwd_q;
	assign mt      = turn_q[15] ? (~turn_q + 16'd1) : turn_q;
	assign speed   = (mf > mt) ? mf : mt;
	assign walking = (mf > {1'b0, cfg.deadband}) || (mt > {1'b0, cfg.deadband});

	assign inc_prod   = 38'(prod_q) * 38'(cfg.rate);
	assign next_phase = walk_q ? (phase_q + inc_prod[30:15]) : 16'd0;

	assign in_ready  = (state_q == F_IDLE);
	assign push      = (state_q == F_PUSH);
	assign push_data = '{walk: walk_q, phase: next_phase, fwd: fwd_q, turn: turn_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			phase_q <= 16'd0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (in_valid) state_q <= F_MUL;
				end
				F_MUL: begin
					state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (push_ready) begin
						phase_q <= next_phase;
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			elapsed_q <= elapsed_ms;
			fwd_q     <= forward_cmd;
			turn_q    <= turn_cmd;
		end
		if (state_q == F_MUL) begin
			prod_q <= 26'(elapsed_q) * 26'(speed);
			walk_q <= walking;
		end
	end

endmodule

[src/tgsg_fifo.sv]
`timescale 1ns / 1ps
module tgsg_fifo import tgsg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  tgsg_tick_t push_data,
	output logic       push_ready,
	input  logic       pop,
	output logic       head_valid,
	output tgsg_tick_t head_data
);

	tgsg_tick_t  mem_q [0:1];
	logic [1:0]  count_q;
	logic        wr_q;
	logic        rd_q;
	logic        do_push;

	assign push_ready = (count_q != 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_data  = mem_q[rd_q];
	assign do_push    = push && push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
		end else begin
			if (do_push) wr_q <= ~wr_q;
			if (pop)     rd_q <= ~rd_q;
			case ({do_push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_data;
	end

endmodule

[src/tgsg_back.sv]
`timescale 1ns / 1ps
module tgsg_back import tgsg_pkg::*; #(
	parameter int LEG_COUNT        = 6,
	parameter int SINE_TABLE_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  tgsg_cfg_t   cfg,
	input  logic        head_valid,
	input  tgsg_tick_t  head_data,
	output logic        pop,
	output logic        mid_item,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  leg,
	output logic [11:0] pulse_tick,
	output logic        last
);

	localparam logic [2:0] LAST_LEG = 3'(LEG_COUNT - 1);
	localparam int FULL = 4 * SINE_TABLE_DEPTH;
	localparam int IW   = $clog2(FULL);
	localparam int PW   = 16 + IW;
	localparam int AW   = $clog2(SINE_TABLE_DEPTH + 1);
	localparam logic [IW-1:0] Q1_BASE = IW'(SINE_TABLE_DEPTH);
	localparam logic [IW-1:0] Q2_BASE = IW'(2 * SINE_TABLE_DEPTH);
	localparam logic [IW-1:0] Q3_BASE = IW'(3 * SINE_TABLE_DEPTH);

	logic [14:0] sine_rom [0:SINE_TABLE_DEPTH];

	for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
		localparam logic [63:0] XPOS = (64'(k) << 30) / SINE_TABLE_DEPTH;
		assign sine_rom[k] = tgsg_sine_entry(XPOS);
	end

	logic        adv;
	logic        issue;
	logic [2:0]  leg_q;

	assign adv      = !out_valid || out_ready;
	assign issue    = adv && head_valid;
	assign pop      = issue && (leg_q == LAST_LEG);
	assign mid_item = (leg_q != 3'd0);

	// issue stage
	logic               left;
	logic               group;
	logic signed [17:0] fwd2;
	logic signed [17:0] turn_x;
	logic signed [17:0] s_val;
	logic [16:0]        ms;
	logic [15:0]        lphase;
	logic [PW-1:0]      idx_prod;
	logic [IW-1:0]      idx;
	logic [1:0]         quad;
	logic [IW-1:0]      qbase;
	logic [IW-1:0]      w_full;
	logic [AW-1:0]      w;
	logic [AW-1:0]      addr;

	assign left   = leg_q[0];
	assign group  = leg_q[1] ^ leg_q[0];
	assign fwd2   = {head_data.fwd[15], head_data.fwd, 1'b0};
	assign turn_x = {{2{head_data.turn[15]}}, head_data.turn};
	assign s_val  = left ? (fwd2 - turn_x) : (fwd2 + turn_x);
	assign ms     = s_val[17] ? 17'(-s_val) : s_val[16:0];
	assign lphase = head_data.phase + {group, 15'd0};

	assign idx_prod = PW'(lphase) * PW'(FULL);
	assign idx      = idx_prod[PW-1:16];

	always_comb begin
		if (idx >= Q3_BASE) begin
			quad  = 2'd3;
			qbase = Q3_BASE;
		end else if (idx >= Q2_BASE) begin
			quad  = 2'd2;
			qbase = Q2_BASE;
		end else if (idx >= Q1_BASE) begin
			quad  = 2'd1;
			qbase = Q1_BASE;
		end else begin
			quad  = 2'd0;
			qbase = '0;
		end
	end

	assign w_full = idx - qbase;
	assign w      = w_full[AW-1:0];
	assign addr   = quad[0] ? (AW'(SINE_TABLE_DEPTH) - w) : w;

	// shared per-item terms from configuration
	logic [13:0] cap;
	logic [14:0] center_cd;
	logic        dneg;
	logic [14:0] dmag;

	assign cap       = 14'(cfg.swing) * CENTI;
	assign center_cd = 15'(cfg.center) * 15'(CENTI);
	assign dneg      = (cfg.pmax < cfg.pmin);
	assign dmag      = dneg ? (cfg.pmin - cfg.pmax) : (cfg.pmax - cfg.pmin);

	// stage valids
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic [2:0] leg_s1, leg_s2, leg_s3, leg_s4, leg_s5, leg_s6, leg_s7, leg_s8, leg_s9;
	logic last_s1, last_s2, last_s3, last_s4, last_s5, last_s6, last_s7, last_s8, last_s9;

	logic        walk_s1, walk_s2, walk_s3;
	logic [16:0] ms_s1;
	logic        neg_s1, neg_s2, neg_s3;
	logic        qneg_s1;
	logic [14:0] sin_s1, sin_s2;
	logic [30:0] prod_s2;
	logic [28:0] swing_s3;
	logic [14:0] angle_s4;
	logic [29:0] mag_s5, mag_s6;
	logic        dneg_s5, dneg_s6, dneg_s7;
	logic [14:0] qa_s6;
	logic [14:0] q_s7;
	logic [14:0] us_s8;
	logic [21:0] n2_s9;
	logic [12:0] qa2_s9;

	logic [2:0]  res_leg_q;
	logic [11:0] res_tick_q;
	logic        res_last_q;
	logic        res_valid_q;

	// stage 3 terms
	logic [14:0] amag_raw;
	logic [13:0] amag;
	assign amag_raw = prod_s2[30:16];
	assign amag     = (amag_raw > {1'b0, cap}) ? cap : amag_raw[13:0];

	// stage 4 terms
	logic [13:0] swing;
	logic [16:0] angle_w;
	logic [14:0] angle_c;
	assign swing = swing_s3[28:15];
	always_comb begin
		if (!walk_s3) begin
			angle_w = 17'(center_cd);
		end else if (neg_s3) begin
			angle_w = 17'(center_cd) - 17'(swing);
		end else begin
			angle_w = 17'(center_cd) + 17'(swing);
		end
		if (angle_w[16]) begin
			angle_c = 15'd0;
		end else if (angle_w[15:0] > 16'(ANGLE_MAX)) begin
			angle_c = ANGLE_MAX;
		end else begin
			angle_c = angle_w[14:0];
		end
	end

	// stage 6 and 7 terms: divide by 18000
	logic [45:0] qa_prod;
	logic [29:0] rem_a;
	assign qa_prod = 46'(mag_s5) * 46'(RECIP_ANGLE);
	assign rem_a   = mag_s6 - 30'(qa_s6) * 30'(ANGLE_MAX);

	// stage 8 terms
	logic [16:0] us_w;
	assign us_w = dneg_s7 ? (17'(cfg.pmin) - 17'(q_s7)) : (17'(cfg.pmin) + 17'(q_s7));

	// stage 9 and output terms: divide by 625
	logic [21:0] n2;
	logic [34:0] qa2_prod;
	logic [21:0] rem_t;
	logic [12:0] tick_q;
	assign n2       = {us_s8, 7'd0};
	assign qa2_prod = 35'(n2) * 35'(RECIP_TICK);
	assign rem_t    = n2_s9 - 22'(qa2_s9) * 22'(TICK_DIV);
	assign tick_q   = (rem_t >= 22'(TICK_DIV)) ? (qa2_s9 + 13'd1) : qa2_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leg_q       <= 3'd0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			v_s7        <= 1'b0;
			v_s8        <= 1'b0;
			v_s9        <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (adv) begin
			if (issue) leg_q <= pop ? 3'd0 : (leg_q + 3'd1);
			v_s1        <= issue;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			v_s6        <= v_s5;
			v_s7        <= v_s6;
			v_s8        <= v_s7;
			v_s9        <= v_s8;
			res_valid_q <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			leg_s1  <= leg_q;
			last_s1 <= (leg_q == LAST_LEG);
			walk_s1 <= head_data.walk;
			ms_s1   <= ms;
			neg_s1  <= s_val[17] ^ left;
			qneg_s1 <= quad[1];
			sin_s1  <= sine_rom[addr];

			leg_s2  <= leg_s1;
			last_s2 <= last_s1;
			walk_s2 <= walk_s1;
			prod_s2 <= 31'(ms_s1) * 31'(cap);
			neg_s2  <= neg_s1 ^ (qneg_s1 && (sin_s1 != 15'd0));
			sin_s2  <= sin_s1;

			leg_s3   <= leg_s2;
			last_s3  <= last_s2;
			walk_s3  <= walk_s2;
			neg_s3   <= neg_s2;
			swing_s3 <= 29'(amag) * 29'(sin_s2);

			leg_s4   <= leg_s3;
			last_s4  <= last_s3;
			angle_s4 <= angle_c;

			leg_s5  <= leg_s4;
			last_s5 <= last_s4;
			mag_s5  <= 30'(angle_s4) * 30'(dmag);
			dneg_s5 <= dneg;

			leg_s6  <= leg_s5;
			last_s6 <= last_s5;
			mag_s6  <= mag_s5;
			dneg_s6 <= dneg_s5;
			qa_s6   <= qa_prod[44:30];

			leg_s7  <= leg_s6;
			last_s7 <= last_s6;
			dneg_s7 <= dneg_s6;
			q_s7    <= (rem_a >= 30'(ANGLE_MAX)) ? (qa_s6 + 15'd1) : qa_s6;

			leg_s8  <= leg_s7;
			last_s8 <= last_s7;
			us_s8   <= us_w[16] ? 15'd0 : us_w[14:0];

			leg_s9  <= leg_s8;
			last_s9 <= last_s8;
			n2_s9   <= n2;
			qa2_s9  <= qa2_prod[34:22];

			res_leg_q  <= leg_s9;
			res_last_q <= last_s9;
			res_tick_q <= (tick_q > 13'(TICK_MAX)) ? TICK_MAX : tick_q[11:0];
		end
	end

	assign out_valid  = res_valid_q;
	assign leg        = res_leg_q;
	assign pulse_tick = res_tick_q;
	assign last       = res_last_q;

endmodule
